>>> src/iae_pkg.sv
// ---------------------------------------------------------------------------
// Infix add/multiply evaluator package
// Token kinds and the queued token type shared by front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

package iae_pkg;

  typedef enum logic [1:0] {
    TOK_NUM   = 2'd0,
    TOK_PLUS  = 2'd1,
    TOK_TIMES = 2'd2,
    TOK_END   = 2'd3
  } tok_kind_e;

  localparam int unsigned TOKEN_WIDTH = 31;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    tok_kind_e               kind;
    logic [TOKEN_WIDTH-1:0]  value;
  } tok_t;

endpackage

`default_nettype wire

>>> src/iae_front.sv
// ---------------------------------------------------------------------------
// Infix evaluator front end
// Accepts token beats, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
`default_nettype none

module iae_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [iae_pkg::TOKEN_WIDTH-1:0] token_value_i,
  output logic                                 tok_valid_o,
  output iae_pkg::tok_t                        tok_o,
  input  wire logic                            tok_pop_i
);

  localparam int unsigned PtrW = (iae_pkg::QUEUE_DEPTH > 1) ? $clog2(iae_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(iae_pkg::QUEUE_DEPTH + 1);

  iae_pkg::tok_t        mem_q [iae_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  iae_pkg::tok_t        in_tok;
  logic                 push;
  logic                 pop;

  assign in_tok.kind  = iae_pkg::tok_kind_e'(req_type_i);
  assign in_tok.value = token_value_i;

  assign in_stall_o  = (count_q == CntW'(iae_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_valid_o = (count_q != '0);
  assign tok_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(iae_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(iae_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_tok;
    end
  end

endmodule

`default_nettype wire

>>> src/iae_back.sv
// ---------------------------------------------------------------------------
// Infix evaluator back end
// Evaluates queued tokens on a two-entry operand stack and registers results.
// ---------------------------------------------------------------------------
`default_nettype none

module iae_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         tok_valid_i,
  input  wire iae_pkg::tok_t tok_i,
  output logic              tok_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic              status_o
);

  logic [VALUE_WIDTH-1:0] s0_q, s0_d;
  logic [VALUE_WIDTH-1:0] s1_q, s1_d;
  logic [1:0]             depth_q, depth_d;
  logic                   plus_q, plus_d;
  logic                   times_q, times_d;
  logic                   expect_q, expect_d;
  logic                   mal_q, mal_d;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            result_q, result_d;
  logic                   status_q, status_d;

  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mul_a;
  logic [VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0] sum;
  logic                   out_free;
  logic                   bad;

  assign v        = VALUE_WIDTH'(tok_i.value);
  assign mul_a    = (depth_q == 2'd1) ? s0_q : s1_q;
  assign prod     = VALUE_WIDTH'(mul_a * v);
  assign sum      = s0_q + s1_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign bad      = mal_q || expect_q || (depth_q == 2'd0);

  assign tok_pop_o = tok_valid_i && ((tok_i.kind != iae_pkg::TOK_END) || out_free);

  always_comb begin
    s0_d        = s0_q;
    s1_d        = s1_q;
    depth_d     = depth_q;
    plus_d      = plus_q;
    times_d     = times_q;
    expect_d    = expect_q;
    mal_d       = mal_q;
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    status_d    = status_q;
    if (tok_pop_o) begin
      case (tok_i.kind)
        iae_pkg::TOK_END: begin
          out_valid_d = 1'b1;
          status_d    = bad;
          if (bad) begin
            result_d = '0;
          end else if (plus_q && depth_q == 2'd2) begin
            result_d = 32'(sum);
          end else begin
            result_d = 32'(s0_q);
          end
          s0_d     = '0;
          s1_d     = '0;
          depth_d  = '0;
          plus_d   = 1'b0;
          times_d  = 1'b0;
          expect_d = 1'b1;
          mal_d    = 1'b0;
        end
        iae_pkg::TOK_NUM: begin
          if (!mal_q) begin
            if (!expect_q) begin
              mal_d = 1'b1;
            end else begin
              expect_d = 1'b0;
              if (times_q && depth_q != 2'd0) begin
                times_d = 1'b0;
                if (depth_q == 2'd1) begin
                  s0_d = prod;
                end else begin
                  s1_d = prod;
                end
              end else if (depth_q == 2'd0) begin
                s0_d    = v;
                depth_d = 2'd1;
              end else if (depth_q == 2'd1) begin
                s1_d    = v;
                depth_d = 2'd2;
              end
            end
          end
        end
        iae_pkg::TOK_PLUS: begin
          if (!mal_q) begin
            if (expect_q) begin
              mal_d = 1'b1;
            end else begin
              if (plus_q && depth_q == 2'd2) begin
                s0_d    = sum;
                s1_d    = '0;
                depth_d = 2'd1;
              end
              plus_d   = 1'b1;
              expect_d = 1'b1;
            end
          end
        end
        iae_pkg::TOK_TIMES: begin
          if (!mal_q) begin
            if (expect_q) begin
              mal_d = 1'b1;
            end else begin
              times_d  = 1'b1;
              expect_d = 1'b1;
            end
          end
        end
        default: begin
          mal_d = mal_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q        <= '0;
      s1_q        <= '0;
      depth_q     <= '0;
      plus_q      <= 1'b0;
      times_q     <= 1'b0;
      expect_q    <= 1'b1;
      mal_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_q        <= s0_d;
      s1_q        <= s1_d;
      depth_q     <= depth_d;
      plus_q      <= plus_d;
      times_q     <= times_d;
      expect_q    <= expect_d;
      mal_q       <= mal_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    status_q <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = $signed(result_q);
  assign status_o       = status_q;

endmodule

`default_nettype wire

>>> src/infix_add_mul_evaluator.sv
// A result beat is registered and presented in the cycle after its end token is taken.
// Throughput: one token per cycle unless a stalled result holds an end token;
// the back end does at most one multiply or add per token on its two-entry operand stack.
// Reset clears the token queue, the evaluator state and the result valid.
// ---------------------------------------------------------------------------
// Infix add/multiply evaluator
// Evaluates a token stream of numbers, plus and times with operator precedence.
// ---------------------------------------------------------------------------
`default_nettype none

module infix_add_mul_evaluator #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [iae_pkg::TOKEN_WIDTH-1:0] token_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [31:0]                   result_value_o,
  output logic                                 status_o
);

  logic          tok_valid;
  iae_pkg::tok_t tok;
  logic          tok_pop;

  iae_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .token_value_i (token_value_i),
    .tok_valid_o   (tok_valid),
    .tok_o         (tok),
    .tok_pop_i     (tok_pop)
  );

  iae_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (tok_valid),
    .tok_i          (tok),
    .tok_pop_o      (tok_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid && (tok.kind != iae_pkg::TOK_END) |-> tok_pop)
    else $error("non-end token left in queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop |-> tok_valid)
    else $error("pop from empty token queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tok_pop && (tok.kind == iae_pkg::TOK_END)))
    else $error("result beat without end token");

endmodule

`default_nettype wire
